// ===== hw/rtl/pdr_pkg.sv =====
// Shared types, constants and a saturating add helper for the reprojection residual block.
package pdr_pkg;

    localparam int FRAC = 28;

    // divider: magnitude of x or y shifted up by FRAC, DIV_STEP quotient bits per stage
    localparam int DIV_BITS   = 32 + FRAC;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    localparam int CORE_LAT = 25;
    // input register + divider + distortion/projection core
    localparam int PIPE_LAT = 1 + DIV_LAT + CORE_LAT;

    localparam logic signed [63:0] LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE   = 64'sh0000_0000_1000_0000;

    localparam logic signed [64:0] OUT_MAX65 = 65'sh0_0000_7FFF_FFFF_FFFF;
    localparam logic signed [64:0] OUT_MIN65 = -65'sh0_0000_8000_0000_0000;
    localparam logic signed [47:0] PENALTY   = 48'sd65536000000;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_K1 = 3'd4,
        REG_RADIAL_K2 = 3'd5,
        REG_RADIAL_K3 = 3'd6,
        REG_TANGENTIAL = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [31:0]        obs_u;
        logic [31:0]        obs_v;
    } item_t;

    typedef struct packed {
        logic signed [47:0] residual_u;
        logic signed [47:0] residual_v;
        logic               behind_camera;
    } result_t;

    typedef struct packed {
        logic [31:0]        focal_x;
        logic [31:0]        focal_y;
        logic [31:0]        center_x;
        logic [31:0]        center_y;
        logic signed [31:0] radial_k1;
        logic signed [31:0] radial_k2;
        logic signed [31:0] radial_k3;
        logic [63:0]        tangential_pair;
    } cfg_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
    } pair_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > LIM65) begin
            return LIM;
        end
        if (s < -LIM65) begin
            return -LIM;
        end
        return s[63:0];
    endfunction

endpackage

// ===== hw/rtl/pdr_div.sv =====
// Pipelined restoring divider: trunc(num * 2^FRAC / den), den positive.
module pdr_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [63:0] quo
);

    typedef struct packed {
        logic [pdr_pkg::DIV_BITS-1:0] qd;   // dividend bits out the top, quotient bits in
        logic [30:0]                  rem;
        logic [30:0]                  dvs;
        logic                         neg;
    } div_st_t;

    div_st_t            st_reg [pdr_pkg::DIV_STAGES];
    div_st_t            init;
    logic [31:0]        mag;
    logic signed [63:0] quo_reg;

    function automatic div_st_t step(input div_st_t s);
        div_st_t     r;
        logic [31:0] t;
        logic [31:0] d;
        r = s;
        for (int i = 0; i < pdr_pkg::DIV_STEP; i++) begin
            t = {r.rem, r.qd[pdr_pkg::DIV_BITS-1]};
            d = t - {1'b0, r.dvs};
            if (t >= {1'b0, r.dvs}) begin
                r.rem = d[30:0];
                r.qd  = {r.qd[pdr_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                r.rem = t[30:0];
                r.qd  = {r.qd[pdr_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb begin
        mag      = num[31] ? $unsigned(-num) : $unsigned(num);
        init.qd  = {mag, {pdr_pkg::FRAC{1'b0}}};
        init.rem = '0;
        init.dvs = den[30:0];
        init.neg = num[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= step(init);
            for (int k = 1; k < pdr_pkg::DIV_STAGES; k++) begin
                st_reg[k] <= step(st_reg[k-1]);
            end
            if (st_reg[pdr_pkg::DIV_STAGES-1].neg)
                quo_reg <= -$signed(64'(st_reg[pdr_pkg::DIV_STAGES-1].qd));
            else
                quo_reg <= $signed(64'(st_reg[pdr_pkg::DIV_STAGES-1].qd));
        end
    end

    assign quo = quo_reg;

endmodule

// ===== hw/rtl/pdr_mul.sv =====
// Three-stage signed Q.28 multiplier: 31-bit partial products, sum, shift and clamp.
module pdr_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] na, nb;
    logic [61:0]        ma, mb;
    logic [61:0]        ll_reg, lh_reg, hl_reg, hh_reg;
    logic               neg1_reg, neg2_reg;
    logic [123:0]       prod_reg;
    logic [61:0]        mag;
    logic signed [63:0] p_reg;

    always_comb begin
        na  = -a;
        nb  = -b;
        ma  = a[63] ? na[61:0] : a[61:0];
        mb  = b[63] ? nb[61:0] : b[61:0];
        // anything at or above 2^62 after the shift clamps to the limit
        mag = (|prod_reg[123:90]) ? {62{1'b1}} : prod_reg[89:28];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ma[30:0]  * mb[30:0];
            lh_reg   <= ma[30:0]  * mb[61:31];
            hl_reg   <= ma[61:31] * mb[30:0];
            hh_reg   <= ma[61:31] * mb[61:31];
            neg1_reg <= a[63] ^ b[63];

            prod_reg <= 124'(ll_reg) + (124'(lh_reg) << 31) + (124'(hl_reg) << 31)
                      + (124'(hh_reg) << 62);
            neg2_reg <= neg1_reg;

            if (neg2_reg)
                p_reg <= -$signed({2'b00, mag});
            else
                p_reg <= $signed({2'b00, mag});
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/pdr_core.sv =====
// Distortion and projection datapath: normalized point in, projected pixel out.
module pdr_core (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] xn,
    input  logic signed [63:0] yn,
    input  pdr_pkg::cfg_t      cfg,
    output logic signed [63:0] u,
    output logic signed [63:0] v
);

    localparam int XN_DLY  = 16;
    localparam int R2_DLY  = 4;
    localparam int S2_DLY  = 3;
    localparam int RAD_DLY = 3;
    localparam int B_DLY   = 11;
    localparam int C_DLY   = 9;

    logic signed [63:0] k1e, k2e, k3e, p1e, p2e, fxe, fye, cxe, cye;

    logic signed [63:0] xx_w, yy_w, xy_w;
    logic signed [63:0] r4_w, t1_w, a1_w, a2_w;
    logic signed [63:0] r6_w, t2_w, c1_w, c2_w;
    logic signed [63:0] t3_w, mx_w, my_w, fu_w, fv_w;

    pdr_pkg::pair_t     xn_dly [XN_DLY];
    logic signed [63:0] r2_reg, xy_d_reg, r4_d_reg, r6_d_reg;
    logic signed [63:0] rad1_reg, rad2_reg, rad_reg;
    logic signed [63:0] r2_dly [R2_DLY];
    pdr_pkg::pair_t     s2_reg, s_reg, b_reg;
    pdr_pkg::pair_t     s2_dly [S2_DLY];
    logic signed [63:0] rad1_dly [RAD_DLY];
    logic signed [63:0] rad2_dly [RAD_DLY];
    pdr_pkg::pair_t     b_dly [B_DLY];
    pdr_pkg::pair_t     c_dly [C_DLY];
    pdr_pkg::pair_t     xd1_reg, xd_reg, uv_reg;

    always_comb begin
        k1e = {{32{cfg.radial_k1[31]}}, cfg.radial_k1};
        k2e = {{32{cfg.radial_k2[31]}}, cfg.radial_k2};
        k3e = {{32{cfg.radial_k3[31]}}, cfg.radial_k3};
        p1e = {{32{cfg.tangential_pair[31]}}, cfg.tangential_pair[31:0]};
        p2e = {{32{cfg.tangential_pair[63]}}, cfg.tangential_pair[63:32]};
        fxe = {32'b0, cfg.focal_x};
        fye = {32'b0, cfg.focal_y};
        cxe = {32'b0, cfg.center_x};
        cye = {32'b0, cfg.center_y};
    end

    // squares and cross term
    pdr_mul u_mul_xx (.clk, .en, .a(xn), .b(xn), .p(xx_w));
    pdr_mul u_mul_yy (.clk, .en, .a(yn), .b(yn), .p(yy_w));
    pdr_mul u_mul_xy (.clk, .en, .a(xn), .b(yn), .p(xy_w));

    // r^4, first radial term, tangential cross products
    pdr_mul u_mul_r4 (.clk, .en, .a(r2_reg), .b(r2_reg),   .p(r4_w));
    pdr_mul u_mul_t1 (.clk, .en, .a(k1e),    .b(r2_reg),   .p(t1_w));
    pdr_mul u_mul_a1 (.clk, .en, .a(p1e),    .b(xy_d_reg), .p(a1_w));
    pdr_mul u_mul_a2 (.clk, .en, .a(p2e),    .b(xy_d_reg), .p(a2_w));

    // r^6, second radial term, tangential square terms
    pdr_mul u_mul_r6 (.clk, .en, .a(r4_d_reg), .b(r2_dly[R2_DLY-1]), .p(r6_w));
    pdr_mul u_mul_t2 (.clk, .en, .a(k2e),      .b(r4_d_reg),         .p(t2_w));
    pdr_mul u_mul_c1 (.clk, .en, .a(p2e),      .b(s_reg.x),          .p(c1_w));
    pdr_mul u_mul_c2 (.clk, .en, .a(p1e),      .b(s_reg.y),          .p(c2_w));

    pdr_mul u_mul_t3 (.clk, .en, .a(k3e), .b(r6_d_reg), .p(t3_w));

    pdr_mul u_mul_mx (.clk, .en, .a(xn_dly[XN_DLY-1].x), .b(rad_reg), .p(mx_w));
    pdr_mul u_mul_my (.clk, .en, .a(xn_dly[XN_DLY-1].y), .b(rad_reg), .p(my_w));

    pdr_mul u_mul_fu (.clk, .en, .a(fxe), .b(xd_reg.x), .p(fu_w));
    pdr_mul u_mul_fv (.clk, .en, .a(fye), .b(xd_reg.y), .p(fv_w));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_dly[0] <= '{x: xn, y: yn};
            for (int i = 1; i < XN_DLY; i++) xn_dly[i] <= xn_dly[i-1];

            r2_reg   <= pdr_pkg::sat_add(xx_w, yy_w);
            s2_reg   <= '{x: pdr_pkg::sat_add(xx_w, xx_w), y: pdr_pkg::sat_add(yy_w, yy_w)};
            xy_d_reg <= xy_w;

            r2_dly[0] <= r2_reg;
            for (int i = 1; i < R2_DLY; i++) r2_dly[i] <= r2_dly[i-1];
            s2_dly[0] <= s2_reg;
            for (int i = 1; i < S2_DLY; i++) s2_dly[i] <= s2_dly[i-1];

            rad1_reg <= pdr_pkg::sat_add(pdr_pkg::ONE, t1_w);
            b_reg    <= '{x: pdr_pkg::sat_add(a1_w, a1_w), y: pdr_pkg::sat_add(a2_w, a2_w)};
            s_reg    <= '{x: pdr_pkg::sat_add(r2_dly[S2_DLY-1], s2_dly[S2_DLY-1].x),
                          y: pdr_pkg::sat_add(r2_dly[S2_DLY-1], s2_dly[S2_DLY-1].y)};
            r4_d_reg <= r4_w;

            rad1_dly[0] <= rad1_reg;
            for (int i = 1; i < RAD_DLY; i++) rad1_dly[i] <= rad1_dly[i-1];
            b_dly[0] <= b_reg;
            for (int i = 1; i < B_DLY; i++) b_dly[i] <= b_dly[i-1];

            rad2_reg <= pdr_pkg::sat_add(rad1_dly[RAD_DLY-1], t2_w);
            r6_d_reg <= r6_w;
            c_dly[0] <= '{x: c1_w, y: c2_w};
            for (int i = 1; i < C_DLY; i++) c_dly[i] <= c_dly[i-1];

            rad2_dly[0] <= rad2_reg;
            for (int i = 1; i < RAD_DLY; i++) rad2_dly[i] <= rad2_dly[i-1];

            rad_reg <= pdr_pkg::sat_add(rad2_dly[RAD_DLY-1], t3_w);

            xd1_reg <= '{x: pdr_pkg::sat_add(mx_w, b_dly[B_DLY-1].x),
                         y: pdr_pkg::sat_add(my_w, b_dly[B_DLY-1].y)};
            xd_reg  <= '{x: pdr_pkg::sat_add(xd1_reg.x, c_dly[C_DLY-1].x),
                         y: pdr_pkg::sat_add(xd1_reg.y, c_dly[C_DLY-1].y)};

            uv_reg  <= '{x: pdr_pkg::sat_add(fu_w, cxe), y: pdr_pkg::sat_add(fv_w, cye)};
        end
    end

    assign u = uv_reg.x;
    assign v = uv_reg.y;

endmodule

// ===== hw/rtl/pinhole_distort_reproject_residual_unit.sv =====
// Top level: config registers, divider and core pipeline, output skid stage.
//
// Reprojection residual with radial/tangential lens distortion.
// item channel: one camera-frame point plus observed pixel per transfer.
// result channel: residual_u/residual_v (observed minus projected, Q32.16,
// saturating) and behind_camera; points with depth <= 0 give the penalty.
// cfg port: write enable, register index, 64-bit data; write only while idle.
// Path: an item passes the input register, 16 divider stages, 25 core stages
// and the output register before its result shows on result_valid.
// Throughput: one item per cycle unless the skid register is full; depth is
// set by the 4-bit-per-stage divider and the 3-stage multipliers of the core.
// Reset: valid bits and the output stage clear; config returns to focal
// length 1.0, principal point 0 and no distortion.
// Stall: the output register plus a skid register absorb one result; while
// the skid register is full, item_ready is low and the whole pipeline holds.
module pinhole_distort_reproject_residual_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  pdr_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output pdr_pkg::result_t    result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    typedef struct packed {
        logic [31:0] obs_u;
        logic [31:0] obs_v;
        logic        behind;
    } side_t;

    pdr_pkg::cfg_t      cfg_reg;
    logic               adv;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic               vld_reg [pdr_pkg::PIPE_LAT];
    side_t              sb_reg  [pdr_pkg::PIPE_LAT];
    logic signed [63:0] xn, yn, u, v;
    logic               fin_valid;
    side_t              fin_sb;
    pdr_pkg::result_t   fin_res;
    logic signed [64:0] du, dv;
    pdr_pkg::result_t   out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x         <= 32'h0001_0000;
            cfg_reg.focal_y         <= 32'h0001_0000;
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y        <= '0;
            cfg_reg.radial_k1       <= '0;
            cfg_reg.radial_k2       <= '0;
            cfg_reg.radial_k3       <= '0;
            cfg_reg.tangential_pair <= '0;
        end
        else if (cfg_we)
        begin
            case (pdr_pkg::cfg_reg_t'(cfg_index))
                pdr_pkg::REG_FOCAL_X:    cfg_reg.focal_x         <= cfg_data[31:0];
                pdr_pkg::REG_FOCAL_Y:    cfg_reg.focal_y         <= cfg_data[31:0];
                pdr_pkg::REG_CENTER_X:   cfg_reg.center_x        <= cfg_data[31:0];
                pdr_pkg::REG_CENTER_Y:   cfg_reg.center_y        <= cfg_data[31:0];
                pdr_pkg::REG_RADIAL_K1:  cfg_reg.radial_k1       <= cfg_data[31:0];
                pdr_pkg::REG_RADIAL_K2:  cfg_reg.radial_k2       <= cfg_data[31:0];
                pdr_pkg::REG_RADIAL_K3:  cfg_reg.radial_k3       <= cfg_data[31:0];
                pdr_pkg::REG_TANGENTIAL: cfg_reg.tangential_pair <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the skid register holds a result
    assign adv        = !skid_valid_reg;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pdr_pkg::PIPE_LAT; i++) vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < pdr_pkg::PIPE_LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= item.point_x;
            py_reg <= item.point_y;
            pz_reg <= item.point_z;
            sb_reg[0] <= '{obs_u: item.obs_u, obs_v: item.obs_v,
                           behind: item.point_z[31] || (item.point_z == '0)};
            for (int i = 1; i < pdr_pkg::PIPE_LAT; i++) sb_reg[i] <= sb_reg[i-1];
        end
    end

    pdr_div u_div_x (.clk, .en(adv), .num(px_reg), .den(pz_reg), .quo(xn));
    pdr_div u_div_y (.clk, .en(adv), .num(py_reg), .den(pz_reg), .quo(yn));

    pdr_core u_core (
        .clk,
        .en  (adv),
        .xn  (xn),
        .yn  (yn),
        .cfg (cfg_reg),
        .u   (u),
        .v   (v)
    );

    always_comb begin
        fin_valid = vld_reg[pdr_pkg::PIPE_LAT-1] && adv;
        fin_sb    = sb_reg[pdr_pkg::PIPE_LAT-1];
        du        = $signed({33'b0, fin_sb.obs_u}) - $signed({u[63], u});
        dv        = $signed({33'b0, fin_sb.obs_v}) - $signed({v[63], v});
        fin_res.behind_camera = fin_sb.behind;
        if (fin_sb.behind)
            fin_res.residual_u = pdr_pkg::PENALTY;
        else if (du > pdr_pkg::OUT_MAX65)
            fin_res.residual_u = pdr_pkg::OUT_MAX65[47:0];
        else if (du < pdr_pkg::OUT_MIN65)
            fin_res.residual_u = pdr_pkg::OUT_MIN65[47:0];
        else
            fin_res.residual_u = du[47:0];
        if (fin_sb.behind)
            fin_res.residual_v = pdr_pkg::PENALTY;
        else if (dv > pdr_pkg::OUT_MAX65)
            fin_res.residual_v = pdr_pkg::OUT_MAX65[47:0];
        else if (dv < pdr_pkg::OUT_MIN65)
            fin_res.residual_v = pdr_pkg::OUT_MIN65[47:0];
        else
            fin_res.residual_v = dv[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_valid;
            end
        end
        else if (fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin_res;
        end
        else if (fin_valid)
        begin
            skid_reg <= fin_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hw/rtl/pdr_check.sv =====
// Port-level checker for the reprojection residual block, bound to the top level.
module pdr_check (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input pdr_pkg::result_t result
);

    localparam int CNT_W = $clog2(pdr_pkg::PIPE_LAT + 4);

    logic [CNT_W-1:0] pend_reg;
    logic             in_xfer, out_xfer;

    assign in_xfer  = item_valid && item_ready;
    assign out_xfer = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_xfer && !out_xfer)
            pend_reg <= pend_reg + 1'b1;
        else if (out_xfer && !in_xfer)
            pend_reg <= pend_reg - 1'b1;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != '0)
        else $error("result without a pending item");

    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with no result waiting");

    a_penalty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.behind_camera |->
            result.residual_u == pdr_pkg::PENALTY && result.residual_v == pdr_pkg::PENALTY)
        else $error("point behind camera without penalty residuals");

endmodule

bind pinhole_distort_reproject_residual_unit pdr_check u_pdr_check (.*);

// ===== dv/pdr_residual_checker.sv =====
// Checker: watches the item, result and config channels, predicts residuals and compares.
module pdr_residual_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  pdr_pkg::item_t    item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  pdr_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    import pdr_pkg::*;

    localparam logic signed [63:0] CLAMP  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] R_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] R_MIN  = -64'sh0000_8000_0000_0000;
    localparam logic signed [47:0] FAR_PENALTY = 48'sd65536000000;

    cfg_t    cam;
    result_t residual_q[$];

    function automatic logic signed [63:0] clip(input logic signed [127:0] v);
        if (v > 128'(CLAMP))
            return CLAMP;
        if (v < -128'(CLAMP))
            return -CLAMP;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return clip(128'(a) + 128'(b));
    endfunction

    // exact product, magnitude truncated toward zero after the shift
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [127:0] p;
        logic [127:0]        m;
        logic                neg;
        p   = 128'(a) * 128'(b);
        neg = p < 0;
        m   = neg ? -p : p;
        m   = m >> FRAC;
        if (m > 128'(CLAMP))
            m = 128'(CLAMP);
        return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic result_t project_residual(input item_t it);
        result_t r;
        logic signed [63:0] xn, yn, xx, yy, xy, r2, r4, r6, rad, xd, yd, u, v, k1, k2, k3;
        logic signed [63:0] p1, p2, ru, rv;
        if (it.point_z <= 0) begin
            r.residual_u    = FAR_PENALTY;
            r.residual_v    = FAR_PENALTY;
            r.behind_camera = 1'b1;
            return r;
        end
        k1 = 64'(cam.radial_k1);
        k2 = 64'(cam.radial_k2);
        k3 = 64'(cam.radial_k3);
        p1 = 64'($signed(cam.tangential_pair[31:0]));
        p2 = 64'($signed(cam.tangential_pair[63:32]));
        xn = (64'(it.point_x) <<< FRAC) / 64'(it.point_z);
        yn = (64'(it.point_y) <<< FRAC) / 64'(it.point_z);
        xx = qmul(xn, xn);
        yy = qmul(yn, yn);
        xy = qmul(xn, yn);
        r2 = sadd(xx, yy);
        r4 = qmul(r2, r2);
        r6 = qmul(r4, r2);
        rad = 64'sd1 <<< FRAC;
        rad = sadd(rad, qmul(k1, r2));
        rad = sadd(rad, qmul(k2, r4));
        rad = sadd(rad, qmul(k3, r6));
        xd = qmul(xn, rad);
        xd = sadd(xd, sadd(qmul(p1, xy), qmul(p1, xy)));
        xd = sadd(xd, qmul(p2, sadd(r2, sadd(xx, xx))));
        yd = qmul(yn, rad);
        yd = sadd(yd, sadd(qmul(p2, xy), qmul(p2, xy)));
        yd = sadd(yd, qmul(p1, sadd(r2, sadd(yy, yy))));
        u = sadd(qmul($signed({32'd0, cam.focal_x}), xd), $signed({32'd0, cam.center_x}));
        v = sadd(qmul($signed({32'd0, cam.focal_y}), yd), $signed({32'd0, cam.center_y}));
        ru = $signed({32'd0, it.obs_u}) - u;
        rv = $signed({32'd0, it.obs_v}) - v;
        ru = ru > R_MAX ? R_MAX : (ru < R_MIN ? R_MIN : ru);
        rv = rv > R_MAX ? R_MAX : (rv < R_MIN ? R_MIN : rv);
        r.residual_u    = ru[47:0];
        r.residual_v    = rv[47:0];
        r.behind_camera = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_count = residual_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            cam.focal_x         <= 32'd65536;
            cam.focal_y         <= 32'd65536;
            cam.center_x        <= '0;
            cam.center_y        <= '0;
            cam.radial_k1       <= '0;
            cam.radial_k2       <= '0;
            cam.radial_k3       <= '0;
            cam.tangential_pair <= '0;
            fail_count   = 0;
            result_count = 0;
            residual_q.delete();
        end else begin
            if (item_valid && item_ready)
                residual_q.push_back(project_residual(item));
            if (result_valid && result_ready) begin
                result_count++;
                if (residual_q.size() == 0) begin
                    report_mismatch("unexpected result", result.residual_u, '0);
                end else begin
                    want = residual_q.pop_front();
                    if (result.residual_u !== want.residual_u)
                        report_mismatch("residual_u", result.residual_u, want.residual_u);
                    if (result.residual_v !== want.residual_v)
                        report_mismatch("residual_v", result.residual_v, want.residual_v);
                    if (result.behind_camera !== want.behind_camera)
                        report_mismatch("behind_camera", 48'(result.behind_camera),
                                        48'(want.behind_camera));
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FOCAL_X:    cam.focal_x         <= cfg_data[31:0];
                    REG_FOCAL_Y:    cam.focal_y         <= cfg_data[31:0];
                    REG_CENTER_X:   cam.center_x        <= cfg_data[31:0];
                    REG_CENTER_Y:   cam.center_y        <= cfg_data[31:0];
                    REG_RADIAL_K1:  cam.radial_k1       <= cfg_data[31:0];
                    REG_RADIAL_K2:  cam.radial_k2       <= cfg_data[31:0];
                    REG_RADIAL_K3:  cam.radial_k3       <= cfg_data[31:0];
                    REG_TANGENTIAL: cam.tangential_pair <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/pinhole_distort_reproject_residual_unit_test.sv =====
// Testbench top: stimulus, configuration phases and verdict for the residual block.
module pinhole_distort_reproject_residual_unit_test;
    import pdr_pkg::*;

    localparam int SETTLE = 60;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int      fail_count, pending_count, result_count;
    int      sent = 0;
    int      stall_mode = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pinhole_distort_reproject_residual_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pdr_residual_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // receiver stall pattern; mode changes over the run, including no stalls
    always @(posedge clk)
    begin
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 3) != 0);
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= ~result_ready;
        endcase
    end

    task automatic send_point(input item_t it);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic go_idle();
        item_valid <= 1'b0;
        item       <= '0;
    endtask

    task automatic drain();
        go_idle();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // cfg_we drops after each write, which keeps back-to-back writes apart
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] small_coef();
        logic signed [31:0] c;
        c = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        return c;
    endfunction

    function automatic item_t random_point();
        item_t it;
        int    kind;
        kind = $urandom_range(0, 9);
        it.obs_u = $urandom();
        it.obs_v = $urandom();
        if (kind < 6) begin
            // typical scene: depth a few units, lateral within the frustum
            it.point_z = $urandom_range(32'h0000_8000, 32'h0040_0000);
            it.point_x = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            it.point_y = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            it.obs_u   = $urandom_range(0, 32'h0800_0000);
            it.obs_v   = $urandom_range(0, 32'h0800_0000);
        end else if (kind < 8) begin
            it.point_x = $urandom();
            it.point_y = $urandom();
            it.point_z = $urandom();
        end else begin
            it.point_x = $urandom();
            it.point_y = $urandom();
            it.point_z = -$signed($urandom_range(0, 1000));
        end
        return it;
    endfunction

    task automatic random_phase(input int count);
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n < count) begin
                send_point(random_point());
                burst--;
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                go_idle();
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic directed();
        item_t it;
        it = '0;
        send_point(it);                         // depth zero
        it.point_z = 32'sh8000_0000;            // most negative depth
        it.point_x = 32'sh7FFF_FFFF;
        send_point(it);
        it.point_z = 32'sh0000_0001;            // tiny depth: saturation
        it.point_x = 32'sh7FFF_FFFF;
        it.point_y = 32'sh8000_0000;
        it.obs_u   = 32'hFFFF_FFFF;
        it.obs_v   = 32'hFFFF_FFFF;
        send_point(it);
        it.point_z = 32'sh7FFF_FFFF;            // largest depth
        send_point(it);
        it.point_x = 32'sh0001_0000;
        it.point_y = -32'sh0001_0000;
        it.point_z = 32'sh0002_0000;
        it.obs_u   = '0;
        it.obs_v   = '0;
        send_point(it);
        it.point_x = -32'sh0000_0001;
        it.point_y = 32'sh0000_0001;
        it.point_z = 32'sh0001_0000;
        it.obs_u   = 32'h8000_0000;
        it.obs_v   = 32'h7FFF_FFFF;
        send_point(it);
        it.point_z = -32'sh0000_0001;
        send_point(it);
    endtask

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        drain();

        // extreme registers
        write_reg(REG_FOCAL_X, 64'hFFFF_FFFF);
        write_reg(REG_FOCAL_Y, 64'hFFFF_FFFF);
        write_reg(REG_CENTER_X, 64'hFFFF_FFFF);
        write_reg(REG_CENTER_Y, 64'hFFFF_FFFF);
        write_reg(REG_RADIAL_K1, 64'h7FFF_FFFF);
        write_reg(REG_RADIAL_K2, 64'h8000_0000);
        write_reg(REG_RADIAL_K3, 64'h7FFF_FFFF);
        write_reg(REG_TANGENTIAL, 64'h8000_0000_7FFF_FFFF);
        stall_mode = 1;
        directed();
        random_phase(60);
        drain();

        // realistic camera
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_FOCAL_X, $urandom_range(32'h0100_0000, 32'h0800_0000));
            write_reg(REG_FOCAL_Y, $urandom_range(32'h0100_0000, 32'h0800_0000));
            write_reg(REG_CENTER_X, $urandom_range(0, 32'h0400_0000));
            write_reg(REG_CENTER_Y, $urandom_range(0, 32'h0400_0000));
            write_reg(REG_RADIAL_K1, small_coef());
            write_reg(REG_RADIAL_K2, small_coef());
            write_reg(REG_RADIAL_K3, small_coef());
            write_reg(REG_TANGENTIAL, {small_coef(), small_coef()});
            stall_mode = ph;
            random_phase(70);
            drain();
        end

        // fully random registers
        write_reg(REG_FOCAL_X, $urandom());
        write_reg(REG_FOCAL_Y, $urandom());
        write_reg(REG_CENTER_X, $urandom());
        write_reg(REG_CENTER_Y, $urandom());
        write_reg(REG_RADIAL_K1, $urandom());
        write_reg(REG_RADIAL_K2, $urandom());
        write_reg(REG_RADIAL_K3, $urandom());
        write_reg(REG_TANGENTIAL, {$urandom(), $urandom()});
        stall_mode = 2;
        random_phase(60);
        drain();

        // zero registers
        write_reg(REG_FOCAL_X, 64'd0);
        write_reg(REG_FOCAL_Y, 64'd0);
        write_reg(REG_CENTER_X, 64'd0);
        write_reg(REG_CENTER_Y, 64'd0);
        write_reg(REG_RADIAL_K1, 64'd0);
        write_reg(REG_RADIAL_K2, 64'd0);
        write_reg(REG_RADIAL_K3, 64'd0);
        write_reg(REG_TANGENTIAL, 64'd0);
        stall_mode = 3;
        random_phase(30);
        drain();

        $display("covered %0d points, %0d results, 8 register settings incl. extremes",
                 sent, result_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
